// File: sv/kkpd_pkg.sv
// Shared types, constants and the CORDIC angle table for the k-space phase drift unit.
package kkpd_pkg;

   localparam int MAX_LOG2_SIDE = 10;
   localparam int SAMPLE_WIDTH  = 48;
   localparam int GUARD         = 12;
   localparam int CORDIC_ITERS  = 31;
   localparam int INDEX_WIDTH   = 30;
   localparam int WORK_WIDTH    = 64;
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   localparam logic [1:0] REG_DIMENSIONS = 2'd0;
   localparam logic [1:0] REG_LOG2_SIDE  = 2'd1;
   localparam logic [1:0] REG_PHASE_STEP = 2'd2;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]  site_index;
      logic [SAMPLE_WIDTH-1:0] re;
      logic [SAMPLE_WIDTH-1:0] im;
   } sample_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [INDEX_WIDTH-1:0]  site_index;
      logic [SAMPLE_WIDTH-1:0] re;
      logic [SAMPLE_WIDTH-1:0] im;
      logic [1:0]              quadrant;
      logic [30:0]             residual;  // signed, [-2^29, 2^29)
      logic [5:0]              shift;
   } task_type;

   typedef struct packed {
      logic [WORK_WIDTH-1:0] x;
      logic [WORK_WIDTH-1:0] y;
      logic [30:0]           z;
   } rot_type;

   function automatic logic [31:0] atan_turns(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/kkpd_front.sv
// Front end: wavenumber, angle and quadrant for each request, three stages.
module kkpd_front import kkpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  sample_type  in_data,
   input  logic [1:0]  dimensions,
   input  logic [3:0]  log2_side,
   input  logic [31:0] phase_step,
   output logic        out_valid,
   output task_type    out_data
);
   localparam int COORD_W = MAX_LOG2_SIDE;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int K2_W    = SQ_W + 2;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   sample_type           s1_data_ff, s2_data_ff, s3_data_ff;
   logic [5:0]           s1_shift_ff, s2_shift_ff, s3_shift_ff;
   logic [COORD_W-1:0]   m_in [3];
   logic [COORD_W-1:0]   m_ff [3];
   logic [K2_W-1:0]      k2_in, k2_ff;
   logic [31:0]          ang_ff;
   logic                 three_d;
   logic [3:0]           lg;
   logic [5:0]           shift_in;
   logic [INDEX_WIDTH-1:0] idx_sh;
   logic [COORD_W:0]     side, half, c;
   logic [31:0]          b;

   always_comb begin
      three_d  = (dimensions == 2'd3);
      lg       = (log2_side > 4'(MAX_LOG2_SIDE)) ? 4'(MAX_LOG2_SIDE) : log2_side;
      side     = (COORD_W+1)'(1) << lg;
      half     = side >> 1;
      shift_in = 6'(GUARD) + (three_d ? 6'(3 * lg) : 6'(2 * lg));
      for (int a = 0; a < 3; a++) begin
         idx_sh = in_data.site_index >> (a * lg);
         c = (COORD_W+1)'(idx_sh) & (side - 1'b1);
         if (a == 0 && !three_d) c = c;
         m_in[a] = (c <= half) ? COORD_W'(c) : COORD_W'(side - c);
         if (a == 2 && !three_d) m_in[a] = '0;
      end
      k2_in = K2_W'(m_ff[0] * m_ff[0]) + K2_W'(m_ff[1] * m_ff[1])
            + K2_W'(m_ff[2] * m_ff[2]);
      b = ang_ff + 32'h20000000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s1_data_ff  <= in_data;
         s1_shift_ff <= shift_in;
         m_ff        <= m_in;
         s2_data_ff  <= s1_data_ff;
         s2_shift_ff <= s1_shift_ff;
         k2_ff       <= k2_in;
         s3_data_ff  <= s2_data_ff;
         s3_shift_ff <= s2_shift_ff;
         ang_ff      <= 32'(phase_step * {{(32-K2_W){1'b0}}, k2_ff});
      end
   end

   assign out_valid           = s3_valid_ff;
   assign out_data.site_index = s3_data_ff.site_index;
   assign out_data.re         = s3_data_ff.re;
   assign out_data.im         = s3_data_ff.im;
   assign out_data.quadrant   = b[31:30];
   assign out_data.residual   = 31'({1'b0, b[29:0]}) - 31'h20000000;
   assign out_data.shift      = s3_shift_ff;
endmodule

// File: sv/kkpd_queue.sv
// Short request queue between front and back ends.
module kkpd_queue import kkpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_data,
   input  logic     pop,
   output logic     not_empty,
   output logic [3:0] fill,
   output task_type pop_data
);
   localparam int DEPTH = 8;
   task_type   mem_ff [DEPTH];
   logic [2:0] wr_ff, rd_ff;
   logic [3:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 3'd1;
         if (pop)  rd_ff <= rd_ff + 3'd1;
         cnt_ff <= cnt_ff + 4'(push) - 4'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign not_empty = (cnt_ff != 4'd0);
   assign fill      = cnt_ff;
   assign pop_data  = mem_ff[rd_ff];
endmodule

// File: sv/kkpd_back.sv
// Back end: gain compensation, quadrant turn, 31 pipelined CORDIC steps, rounding shift.
module kkpd_back import kkpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  task_type in_data,
   output logic     out_valid,
   output sample_type out_data
);
   localparam int N_ST = CORDIC_ITERS;
   localparam int W    = WORK_WIDTH;

   // stage A: gain multiply, low parts registered separately
   logic          a_valid_ff;
   logic [W-1:0]  a_xh_ff, a_yh_ff, a_xl_ff, a_yl_ff;
   task_type      a_task_ff;
   // stage B: compensated value turned by quadrant
   logic          b_valid_ff;
   rot_type       b_rot_ff;
   logic [INDEX_WIDTH-1:0] b_idx_ff;
   logic [5:0]    b_shift_ff;

   logic          c_valid_ff [N_ST];
   rot_type       c_rot_ff   [N_ST];
   logic [INDEX_WIDTH-1:0] c_idx_ff [N_ST];
   logic [5:0]    c_shift_ff [N_ST];
   rot_type       c_rot_in   [N_ST];

   logic          f_valid_ff;
   sample_type    f_data_ff;

   logic signed [W-1:0] xr, yr, xc, yc, xq, yq;
   logic [17:0]   xlo, ylo;

   always_comb begin
      xr  = W'($signed(in_data.re));
      yr  = W'($signed(in_data.im));
      xlo = xr[17:0];
      ylo = yr[17:0];
   end

   always_comb begin
      xc = $signed(a_xh_ff) + $signed(a_xl_ff);
      yc = $signed(a_yh_ff) + $signed(a_yl_ff);
      unique case (a_task_ff.quadrant)
         2'd0: begin xq = xc;  yq = yc;  end
         2'd1: begin xq = -yc; yq = xc;  end
         2'd2: begin xq = -xc; yq = -yc; end
         default: begin xq = yc; yq = -xc; end
      endcase
   end

   always_comb begin
      for (int i = 0; i < N_ST; i++) begin
         rot_type p;
         logic signed [W-1:0] dx, dy;
         p  = (i == 0) ? b_rot_ff : c_rot_ff[(i == 0) ? 0 : i - 1];
         dx = $signed(p.y) >>> i;
         dy = $signed(p.x) >>> i;
         if (!p.z[30]) begin
            c_rot_in[i].x = p.x - dx;
            c_rot_in[i].y = p.y + dy;
            c_rot_in[i].z = p.z - 31'(atan_turns(5'(i)));
         end else begin
            c_rot_in[i].x = p.x + dx;
            c_rot_in[i].y = p.y - dy;
            c_rot_in[i].z = p.z + 31'(atan_turns(5'(i)));
         end
      end
   end

   function automatic logic [SAMPLE_WIDTH-1:0] finish(input logic [W-1:0] v,
                                                      input logic [5:0] s);
      logic signed [W:0] r;
      logic signed [W:0] lim;
      r   = ($signed({v[W-1], v}) + $signed((W+1)'(1) << (s - 6'd1))) >>> s;
      lim = (W+1)'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
      if (r > lim) r = lim;
      if (r < -lim - 1) r = -lim - 1;
      return r[SAMPLE_WIDTH-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         for (int i = 0; i < N_ST; i++) c_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff[0] <= b_valid_ff;
         for (int i = 1; i < N_ST; i++) c_valid_ff[i] <= c_valid_ff[i-1];
         f_valid_ff <= c_valid_ff[N_ST-1];
      end
      if (advance) begin
         a_task_ff <= in_data;
         // upper 30 bits of the sample times the 31-bit signed gain
         a_xh_ff <= W'($signed(xr[SAMPLE_WIDTH-1:18]) * $signed({1'b0, GAIN_Q30}));
         a_yh_ff <= W'($signed(yr[SAMPLE_WIDTH-1:18]) * $signed({1'b0, GAIN_Q30}));
         a_xl_ff <= W'((48'(xlo) * 48'(GAIN_Q30) + 48'h20000) >> 18);
         a_yl_ff <= W'((48'(ylo) * 48'(GAIN_Q30) + 48'h20000) >> 18);
         b_rot_ff.x <= xq;
         b_rot_ff.y <= yq;
         b_rot_ff.z <= a_task_ff.residual;
         b_idx_ff   <= a_task_ff.site_index;
         b_shift_ff <= a_task_ff.shift;
         c_rot_ff[0]   <= c_rot_in[0];
         c_idx_ff[0]   <= b_idx_ff;
         c_shift_ff[0] <= b_shift_ff;
         for (int i = 1; i < N_ST; i++) begin
            c_rot_ff[i]   <= c_rot_in[i];
            c_idx_ff[i]   <= c_idx_ff[i-1];
            c_shift_ff[i] <= c_shift_ff[i-1];
         end
         f_data_ff.site_index <= c_idx_ff[N_ST-1];
         f_data_ff.re <= finish(c_rot_ff[N_ST-1].x, c_shift_ff[N_ST-1]);
         f_data_ff.im <= finish(c_rot_ff[N_ST-1].y, c_shift_ff[N_ST-1]);
      end
   end

   assign out_valid = f_valid_ff;
   assign out_data  = f_data_ff;
endmodule

// File: sv/kspace_kinetic_phase_drift_unit.sv
// Top level of the k-space kinetic phase drift unit: CSRs, front end, queue, back end, skid.
//
//  channel | direction | handshake        | payload
//  req     | in        | tvalid / tready  | site_index, re_in, im_in
//  rsp     | out       | tvalid / tready  | site_index_out, re_out, im_out
//  csr     | in        | APB psel/penable | dimensions, log2_side, phase_step
//
// One request per cycle sustained while the queue has room and the output is taken.
// The back pipeline is 31 unrolled CORDIC stages plus gain, quadrant and rounding stages.
// Synchronous active-high reset empties all stages and restores register defaults.
// The front runs while the queue has room; the back stalls as a whole when the
// output skid stage is full and not taken, without losing results in flight.
module kspace_kinetic_phase_drift_unit import kkpd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // site_index[29:0], re_in[77:30], im_in[125:78], zeros
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // site_index_out[29:0], re_out[77:30], im_out[125:78]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic [1:0]  dimensions_ff;
   logic [3:0]  log2_side_ff;
   logic [31:0] phase_step_ff;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimensions_ff <= 2'd3;
         log2_side_ff  <= 4'd8;
         phase_step_ff <= '0;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[3:2] == REG_DIMENSIONS) dimensions_ff <= csr_pwdata[1:0];
         if (csr_paddr[3:2] == REG_LOG2_SIDE)  log2_side_ff  <= csr_pwdata[3:0];
         if (csr_paddr[3:2] == REG_PHASE_STEP) phase_step_ff <= csr_pwdata;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DIMENSIONS: csr_prdata = {30'd0, dimensions_ff};
         REG_LOG2_SIDE:  csr_prdata = {28'd0, log2_side_ff};
         REG_PHASE_STEP: csr_prdata = phase_step_ff;
         default:        csr_prdata = '0;
      endcase
   end

   sample_type req;
   assign req.site_index = req_tdata[29:0];
   assign req.re         = req_tdata[77:30];
   assign req.im         = req_tdata[125:78];

   // front advances only while the queue can absorb everything in flight (3 stages)
   logic       f_valid, q_ne, q_pop, b_adv, b_valid;
   logic [3:0] q_fill;
   task_type   f_data, q_data;
   sample_type b_data;
   logic       f_adv;

   assign f_adv      = (q_fill <= 4'd4);
   assign req_tready = f_adv;

   kkpd_front u_front (
      .clock, .reset, .advance(f_adv), .in_valid(req_tvalid), .in_data(req),
      .dimensions(dimensions_ff), .log2_side(log2_side_ff), .phase_step(phase_step_ff),
      .out_valid(f_valid), .out_data(f_data));

   kkpd_queue u_queue (
      .clock, .reset, .push(f_valid && f_adv), .push_data(f_data),
      .pop(q_pop), .not_empty(q_ne), .fill(q_fill), .pop_data(q_data));

   // output skid: back stalls only when a result is held and not taken
   logic       out_valid_ff;
   sample_type out_data_ff;
   assign b_adv = !out_valid_ff || rsp_tready;
   assign q_pop = q_ne && b_adv;

   kkpd_back u_back (
      .clock, .reset, .advance(b_adv), .in_valid(q_pop), .in_data(q_data),
      .out_valid(b_valid), .out_data(b_data));

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (b_adv) out_valid_ff <= b_valid;
      if (b_adv) out_data_ff <= b_data;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff.im, out_data_ff.re, out_data_ff.site_index};
endmodule

// File: sv/kkpd_checker.sv
// Port-level checker for the k-space phase drift unit, bound to the top level.
module kkpd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped while stalled");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[127:126] == 2'b00)
      else $error("rsp padding not zero");
   a_rdy: assert property (@(posedge clock) csr_pready)
      else $error("csr pready low");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
endmodule

bind kspace_kinetic_phase_drift_unit kkpd_checker u_kkpd_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .csr_pready);

// File: tb/kspace_kinetic_phase_drift_unit_tb.sv
// Self-checking testbench for the k-space kinetic phase drift unit.
`timescale 1ns / 100ps

module kspace_kinetic_phase_drift_unit_tb;
   import kkpd_pkg::*;

   // ---------------------------------------------------------------------
   // clock, reset and the block's pins
   // ---------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;  // site_index[29:0], re_in[77:30], im_in[125:78]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;       // site_index_out[29:0], re_out[77:30], im_out[125:78]
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   kspace_kinetic_phase_drift_unit u_top (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   localparam int LATENCY    = 39;
   localparam int CYCLE_CAP  = 400000;

   // predictor's copy of the registers
   logic [1:0]  grid_dims = 2'd3;
   logic [3:0]  grid_log2 = 4'd8;
   logic [31:0] drift_step = '0;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]  site_index;
      logic [SAMPLE_WIDTH-1:0] re;
      logic [SAMPLE_WIDTH-1:0] im;
   } drift_item;

   drift_item pending_requests[$];   // filled by the stimulus, drained by the driver
   drift_item drifted_samples[$];    // predicted results, oldest first

   int errors = 0;
   int requests_sent = 0;
   int samples_checked = 0;
   int cycle_count = 0;
   bit stimulus_done = 1'b0;
   bit driver_on = 1'b0;

   // arithmetic shift right, flooring
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // gain-compensated value in Q(GUARD) extra fraction bits
   function automatic longint gain_scale(logic [SAMPLE_WIDTH-1:0] raw);
      longint v, hi;
      longint unsigned lo, frac;
      v = longint'($signed(raw));
      hi = v >>> 18;
      lo = longint'(v) & 64'h3FFFF;
      frac = (lo * 64'd652032874 + 64'h20000) >> 18;
      return hi * 64'sd652032874 + longint'(frac);
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] round_saturate(longint v, int s);
      longint r, lim;
      lim = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
      r = v;
      if (s > 0) r = (v + (64'sd1 <<< (s - 1))) >>> s;
      if (r > lim) r = lim;
      if (r < -lim - 1) r = -lim - 1;
      return r[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] atan_step(int i);
      logic [31:0] t [0:30];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
            32'h00000001};
      return t[i];
   endfunction

   // kinetic phase rotation of one k-space element
   function automatic drift_item predict_drift(drift_item in_item);
      drift_item o;
      int dims, lg, shift;
      longint unsigned side, half, coord, wave, k2;
      logic [31:0] ang, bq;
      logic [1:0] quad;
      longint x, y, t, z, dx, dy;
      dims = (grid_dims == 2'd3) ? 3 : 2;
      lg = (grid_log2 > MAX_LOG2_SIDE) ? MAX_LOG2_SIDE : int'(grid_log2);
      side = 64'd1 << lg;
      half = side >> 1;
      k2 = 0;
      for (int a = 0; a < dims; a++) begin
         coord = (longint'(in_item.site_index) >> (a * lg)) & (side - 1);
         wave = (coord <= half) ? coord : side - coord;
         k2 += wave * wave;
      end
      ang = drift_step * k2[31:0];
      bq = ang + 32'h20000000;
      quad = bq[31:30];
      z = longint'(bq[29:0]) - 64'sh20000000;
      x = gain_scale(in_item.re);
      y = gain_scale(in_item.im);
      case (quad)
         2'd1: begin t = x; x = -y; y = t; end
         2'd2: begin x = -x; y = -y; end
         2'd3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_step(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_step(i));
         end
      end
      shift = GUARD + dims * lg;
      o.site_index = in_item.site_index;
      o.re = round_saturate(x, shift);
      o.im = round_saturate(y, shift);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h want %h (t=%0t)", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of requests with random gaps
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            drifted_samples.push_back(predict_drift(pending_requests.pop_front()));
            requests_sent++;
         end
         // request presented next cycle; a waiting request is held unchanged
         if (req_tvalid && !req_tready) begin
         end else if (driver_on && pending_requests.size() > 0) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, pending_requests[0].im, pending_requests[0].re,
                             pending_requests[0].site_index};
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor and receiver stall pattern
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   drift_item want_item;

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (drifted_samples.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[63:0], 64'd0);
            end else begin
               want_item = drifted_samples.pop_front();
               if (rsp_tdata[29:0] !== want_item.site_index)
                  report_mismatch("site_index_out", 64'(rsp_tdata[29:0]),
                                  64'(want_item.site_index));
               if (rsp_tdata[77:30] !== want_item.re)
                  report_mismatch("re_out", 64'(rsp_tdata[77:30]), 64'(want_item.re));
               if (rsp_tdata[125:78] !== want_item.im)
                  report_mismatch("im_out", 64'(rsp_tdata[125:78]), 64'(want_item.im));
               samples_checked++;
            end
         end
         if ((cycle_count % 200) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ((cycle_count % 7) < 3);
            default: rsp_tready <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout with %0d results outstanding", drifted_samples.size());
         $display("kspace_kinetic_phase_drift_unit test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // register writes through the APB port (block idle)
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [1:0] reg_sel, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (reg_sel)
         REG_DIMENSIONS: grid_dims = value[1:0];
         REG_LOG2_SIDE:  grid_log2 = value[3:0];
         REG_PHASE_STEP: drift_step = value;
         default: ;
      endcase
   endtask

   task automatic drain_requests();
      while (pending_requests.size() > 0 || drifted_samples.size() > 0) @(posedge clock);
      driver_on = 1'b0;
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
         2: return SAMPLE_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
         default: return SAMPLE_WIDTH'({$urandom(), $urandom()});
      endcase
   endfunction

   task automatic queue_request(logic [29:0] idx, logic [47:0] re, logic [47:0] im);
      drift_item it;
      it.site_index = idx; it.re = re; it.im = im;
      pending_requests.push_back(it);
   endtask

   // one configuration phase of random requests
   task automatic run_phase(logic [1:0] dims, logic [3:0] lg, logic [31:0] step, int count);
      csr_write(REG_DIMENSIONS, {30'($urandom()), dims});
      csr_write(REG_LOG2_SIDE, {28'($urandom()), lg});
      csr_write(REG_PHASE_STEP, step);
      for (int n = 0; n < count; n++)
         queue_request(30'($urandom()), random_sample(), random_sample());
      driver_on = 1'b1;
      drain_requests();
   endtask

   localparam logic [47:0] S_MAX = {1'b0, {47{1'b1}}};
   localparam logic [47:0] S_MIN = {1'b1, {47{1'b0}}};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, zero step, extreme samples and indices
      queue_request(30'd0, S_MAX, S_MAX);
      queue_request(30'h3FFFFFFF, S_MIN, S_MIN);
      queue_request(30'h0, 48'd1, 48'hFFFFFFFFFFFF);
      driver_on = 1'b1;
      drain_requests();
      // directed: quarter turns, half-side coordinates, high index bits ignored
      csr_write(REG_DIMENSIONS, 32'd2);
      csr_write(REG_LOG2_SIDE, 32'd2);
      csr_write(REG_PHASE_STEP, 32'h40000000);
      for (int i = 0; i < 16; i++) queue_request(30'(i) | 30'h20000000, S_MAX, 48'd12345);
      queue_request(30'h3FFFFFF0, S_MIN, S_MAX);
      driver_on = 1'b1;
      drain_requests();
      // directed: log2 side of zero (side of one, no division) and side above the cap
      csr_write(REG_LOG2_SIDE, 32'd0);
      queue_request(30'h155, S_MAX, S_MIN);
      queue_request(30'd7, 48'd1000, 48'd3);
      driver_on = 1'b1;
      drain_requests();
      csr_write(REG_LOG2_SIDE, 32'd15);
      csr_write(REG_DIMENSIONS, 32'd3);
      queue_request(30'h3FFFFFFF, S_MAX, S_MAX);
      queue_request(30'h20080200, S_MIN, 48'd77);
      driver_on = 1'b1;
      drain_requests();

      // random phases across settings, extremes included
      run_phase(2'd3, 4'd10, 32'h7FFFFFFF, 90);
      run_phase(2'd0, 4'd1, 32'h80000000, 80);
      run_phase(2'd1, 4'd4, $urandom(), 90);
      run_phase(2'd2, 4'd10, 32'hFFFFFFFF, 80);
      run_phase(2'd3, 4'd3, $urandom(), 100);
      run_phase(2'd3, 4'(($urandom_range(0, 15))), $urandom(), 100);
      run_phase(2'd2, 4'd6, $urandom(), 100);
      run_phase(2'd3, 4'd8, 32'h00000001, 90);
      stimulus_done = 1'b1;

      $display("covered %0d requests over several grid shapes and phase steps;", requests_sent);
      $display("%0d results checked, %0d mismatches", samples_checked, errors);
      if (errors == 0) begin
         $display("kspace_kinetic_phase_drift_unit test passed");
      end else begin
         $display("kspace_kinetic_phase_drift_unit test failed");
      end
      $finish;
   end

endmodule
